### design/esc_pkg.sv
// esc_pkg: widths, vector type and the controller/datapath command and status
// structs of the enclosing sphere center block
// depends on nothing
`default_nettype none
package esc_pkg;
   localparam int COORD_W    = 32;  // q15.16 signed coordinate
   localparam int RAD_W      = 31;  // q15.16 unsigned radius
   localparam int SUM_W      = 48;  // running coordinate sum
   localparam int CNT_W      = 16;  // child count
   localparam int MAG_W      = 33;  // magnitude of a coordinate difference
   localparam int DIST_W     = 33;  // floor of a center distance
   localparam int SQ_W       = 66;  // sum of three squares
   localparam int REM_W      = 36;  // square root remainder
   localparam int ROOT_STEPS = 33;  // one root bit per step
   localparam int DNUM_W     = 62;  // divider numerator
   localparam int DDEN_W     = 34;  // divider denominator
   localparam int T_W        = 35;  // signed axis shift t
   localparam int TMAG_W     = 34;
   localparam int Q_W        = 30;  // axis ratio quotient, at most 2^29
   localparam int PROD_W     = 64;
   localparam int FRAC_SH    = 29;
   localparam int OFF_W      = 34;
   localparam int VAL_W      = 35;  // distance plus radii

   typedef logic [2:0][COORD_W-1:0] esc_vec_type;

   typedef struct packed {
      logic       load;       // take an item into store and sums
      logic       rd;         // read store entry at the read address
      logic       lat_a;      // point a from store read data
      logic       lat_b;      // point b from store read data
      logic       cand_a;     // point a from a candidate center
      logic       cand_sel;   // 0 mean, 1 axis candidate
      logic       dist_go;
      logic       div_go;
      logic       div_sel;    // 0 mean division, 1 axis ratio
      logic [1:0] axis;
      logic       mean_save;
      logic       pair_init;
      logic       pair_upd;
      logic       t_calc;
      logic       mul;
      logic       axis_save;
      logic       rad_init;
      logic       rad_upd;
      logic       rad_keep;
      logic       out_load;
   } esc_cmd_type;

   typedef struct packed {
      logic             div_done;
      logic             dist_done;
      logic             pair_ok;
      logic             found;
      logic             d_zero;
      logic             out_free;
      logic [CNT_W-1:0] count;
   } esc_stat_type;
endpackage
`default_nettype wire

### design/enclosing_sphere_center.sv
// enclosing_sphere_center: top level, joins the sequencer and the datapath
// depends on esc_pkg, esc_ctrl, esc_dp (which holds esc_div and esc_dist)
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   pos_x/y/z, child_radius, last_child
//   rsp      out        rsp_valid/rsp_stall   center_x/y/z, too_many
//
// a child item is taken whenever req_valid is high while idle; the item marked
// last starts the compute phase, during which req_stall stays high
// compute is a mean division per axis, then, for n of at least two and below
// the store depth, a pair search over all pairs and, if an axis center is found,
// a division per axis for it and a radius check of both candidates over all n;
// the square root unit (33 steps) and the divider (62 steps) are each shared
// the result sits in an output register, so a stalled result only holds the
// block at the end of the next set
// synchronous active-high reset clears sums, count, overflow flag, result valid and control state
`default_nettype none
module enclosing_sphere_center #(
   parameter int STORE_DEPTH = 16,
   parameter int MAX_COUNT   = 65535
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [esc_pkg::COORD_W-1:0]  req_pos_x,
   input  logic [esc_pkg::COORD_W-1:0]  req_pos_y,
   input  logic [esc_pkg::COORD_W-1:0]  req_pos_z,
   input  logic [esc_pkg::RAD_W-1:0]    req_child_radius,
   input  logic                         req_last_child,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [esc_pkg::COORD_W-1:0]  rsp_center_x,
   output logic [esc_pkg::COORD_W-1:0]  rsp_center_y,
   output logic [esc_pkg::COORD_W-1:0]  rsp_center_z,
   output logic                         rsp_too_many
);
   import esc_pkg::*;

   // store address width, at least one bit
   localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   esc_cmd_type       cmd;
   esc_stat_type      stat;
   logic [ADDR_W-1:0] rd_addr;

   // sequencer: load, mean, pair search, axis center, radius compare
   esc_ctrl #(
      .ADDR_W (ADDR_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_child (req_last_child),
      .req_stall      (req_stall),
      .stat           (stat),
      .cmd            (cmd),
      .rd_addr        (rd_addr)
   );

   // store, accumulators, arithmetic units and result register
   esc_dp #(
      .STORE_DEPTH (STORE_DEPTH),
      .MAX_COUNT   (MAX_COUNT),
      .ADDR_W      (ADDR_W)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .rd_addr          (rd_addr),
      .stat             (stat),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_child_radius (req_child_radius),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_center_x     (rsp_center_x),
      .rsp_center_y     (rsp_center_y),
      .rsp_center_z     (rsp_center_z),
      .rsp_too_many     (rsp_too_many)
   );
endmodule
`default_nettype wire

### design/esc_div.sv
// esc_div: restoring divider, one quotient bit per cycle
// depends on esc_pkg
`default_nettype none
module esc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [esc_pkg::DNUM_W-1:0]  num,
   input  logic [esc_pkg::DDEN_W-1:0]  den,
   output logic                        done,
   output logic [esc_pkg::DNUM_W-1:0]  quo
);
   import esc_pkg::*;

   logic                busy_ff;
   logic                done_ff;
   logic [5:0]          cnt_ff;
   logic [DNUM_W-1:0]   num_ff;
   logic [DDEN_W-1:0]   den_ff;
   logic [DDEN_W:0]     rem_ff;
   logic [DNUM_W-1:0]   quo_ff;
   logic [DDEN_W:0]     rem_in;
   logic                ge;

   always_comb begin
      rem_in = {rem_ff[DDEN_W-1:0], num_ff[DNUM_W-1]};
      ge     = rem_in >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (!busy_ff) begin
            if (start) begin
               busy_ff <= 1'b1;
               cnt_ff  <= '0;
               num_ff  <= num;
               den_ff  <= den;
               rem_ff  <= '0;
               quo_ff  <= '0;
            end
         end else begin
            rem_ff <= ge ? (rem_in - {1'b0, den_ff}) : rem_in;
            quo_ff <= {quo_ff[DNUM_W-2:0], ge};
            num_ff <= {num_ff[DNUM_W-2:0], 1'b0};
            if (cnt_ff == 6'(DNUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + 6'd1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule
`default_nettype wire

### design/esc_dist.sv
// esc_dist: floor of the euclidean distance of two points, squares over a
// shared multiplier then a bit-serial square root; depends on esc_pkg
`default_nettype none
module esc_dist (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  esc_pkg::esc_vec_type        pnt_a,
   input  esc_pkg::esc_vec_type        pnt_b,
   output logic                        done,
   output logic [esc_pkg::DIST_W-1:0]  dlen
);
   import esc_pkg::*;

   typedef enum logic [1:0] {D_IDLE, D_SQ, D_ROOT} dstate_type;

   dstate_type        state_ff;
   logic              done_ff;
   logic [2:0]        step_ff;
   logic [5:0]        cnt_ff;
   logic [MAG_W-1:0]  mag_ff;
   logic [SQ_W-1:0]   prod_ff;
   logic [SQ_W-1:0]   acc_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [DIST_W-1:0] root_ff;

   logic [1:0]        sel;
   logic [MAG_W-1:0]  dif;
   logic [MAG_W-1:0]  mag_in;
   logic [REM_W-1:0]  rem_in;
   logic [REM_W-1:0]  trial;
   logic              ge;

   always_comb begin
      sel    = (step_ff < 3'd3) ? step_ff[1:0] : 2'd0;
      dif    = {pnt_a[sel][COORD_W-1], pnt_a[sel]} - {pnt_b[sel][COORD_W-1], pnt_b[sel]};
      mag_in = dif[MAG_W-1] ? (MAG_W'(0) - dif) : dif;
      rem_in = {rem_ff[REM_W-3:0], acc_ff[SQ_W-1 -: 2]};
      trial  = {1'b0, root_ff, 2'b01};
      ge     = rem_in >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            D_IDLE: begin
               if (start) begin
                  step_ff  <= '0;
                  acc_ff   <= '0;
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  state_ff <= D_SQ;
               end
            end
            D_SQ: begin
               if (step_ff < 3'd3) mag_ff <= mag_in;
               if (step_ff >= 3'd1 && step_ff <= 3'd3)
                  prod_ff <= SQ_W'(mag_ff) * SQ_W'(mag_ff);
               if (step_ff >= 3'd2) acc_ff <= acc_ff + prod_ff;
               if (step_ff == 3'd4) begin
                  cnt_ff   <= '0;
                  state_ff <= D_ROOT;
               end else begin
                  step_ff <= step_ff + 3'd1;
               end
            end
            D_ROOT: begin
               rem_ff  <= ge ? (rem_in - trial) : rem_in;
               root_ff <= {root_ff[DIST_W-2:0], ge};
               acc_ff  <= {acc_ff[SQ_W-3:0], 2'b00};
               if (cnt_ff == 6'(ROOT_STEPS - 1)) begin
                  state_ff <= D_IDLE;
                  done_ff  <= 1'b1;
               end else begin
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign dlen = root_ff;
endmodule
`default_nettype wire

### design/esc_dp.sv
// esc_dp: child store, sums, candidate centers, pair and radius tracking and
// the result register; depends on esc_pkg, esc_div and esc_dist
`default_nettype none
module esc_dp #(
   parameter int STORE_DEPTH = 16,
   parameter int MAX_COUNT   = 65535,
   parameter int ADDR_W      = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  esc_pkg::esc_cmd_type         cmd,
   input  logic [ADDR_W-1:0]            rd_addr,
   output esc_pkg::esc_stat_type        stat,
   input  logic [esc_pkg::COORD_W-1:0]  req_pos_x,
   input  logic [esc_pkg::COORD_W-1:0]  req_pos_y,
   input  logic [esc_pkg::COORD_W-1:0]  req_pos_z,
   input  logic [esc_pkg::RAD_W-1:0]    req_child_radius,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [esc_pkg::COORD_W-1:0]  rsp_center_x,
   output logic [esc_pkg::COORD_W-1:0]  rsp_center_y,
   output logic [esc_pkg::COORD_W-1:0]  rsp_center_z,
   output logic                         rsp_too_many
);
   import esc_pkg::*;

   esc_vec_type             mem_p [STORE_DEPTH];
   logic [RAD_W-1:0]        mem_r [STORE_DEPTH];

   logic [2:0][SUM_W-1:0]   sum_ff;
   logic [CNT_W-1:0]        count_ff;
   logic                    ovf_ff;
   esc_vec_type             rdp_ff, pa_ff, pb_ff, s_ff, e_ff, mean_ff, axis_ff, out_ff;
   logic [RAD_W-1:0]        rdr_ff, ra_ff, rb_ff, rs_ff, re_ff;
   logic [VAL_W-1:0]        best_ff, rad_ff, radm_ff;
   logic [DIST_W-1:0]       bestd_ff;
   logic                    found_ff;
   logic [T_W-1:0]          t_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic                    rsp_valid_ff;
   logic                    too_many_ff;

   esc_vec_type             pin;
   logic                    count_ok;
   logic                    dist_done;
   logic [DIST_W-1:0]       dlen;
   logic                    div_done;
   logic [DNUM_W-1:0]       quo;
   logic [DNUM_W-1:0]       div_num;
   logic [DDEN_W-1:0]       div_den;
   logic [SUM_W-1:0]        sum_mag;
   logic [MAG_W-1:0]        dc, dc_mag;
   logic [TMAG_W-1:0]       t_mag;
   logic [PROD_W-1:0]       rnd;
   logic [OFF_W-1:0]        off;
   logic [OFF_W+1:0]        cand;
   logic                    neg_axis;
   logic                    mean_neg;
   logic [COORD_W-1:0]      mean_val, axis_val;
   logic [VAL_W-1:0]        pair_val, need_val;
   logic                    out_free;
   logic                    take_axis;

   always_comb begin
      pin      = {req_pos_z, req_pos_y, req_pos_x};
      count_ok = count_ff < CNT_W'(MAX_COUNT);

      // mean: (2|sum| + n) / 2n
      sum_mag  = sum_ff[cmd.axis][SUM_W-1] ? (SUM_W'(0) - sum_ff[cmd.axis])
                                           : sum_ff[cmd.axis];
      mean_neg = sum_ff[cmd.axis][SUM_W-1];

      // axis ratio: |d_c| * 2^29 / D
      dc       = {e_ff[cmd.axis][COORD_W-1], e_ff[cmd.axis]}
               - {s_ff[cmd.axis][COORD_W-1], s_ff[cmd.axis]};
      dc_mag   = dc[MAG_W-1] ? (MAG_W'(0) - dc) : dc;

      if (cmd.div_sel) begin
         div_num = {dc_mag, {FRAC_SH{1'b0}}};
         div_den = DDEN_W'(bestd_ff);
      end else begin
         div_num = DNUM_W'({sum_mag, 1'b0}) + DNUM_W'(count_ff);
         div_den = DDEN_W'({count_ff, 1'b0});
      end

      if (!mean_neg)
         mean_val = (quo > DNUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo[COORD_W-1:0];
      else
         mean_val = (quo > DNUM_W'(32'h8000_0000)) ? 32'h8000_0000
                                                   : (32'd0 - quo[COORD_W-1:0]);

      t_mag    = t_ff[T_W-1] ? TMAG_W'(T_W'(0) - t_ff) : t_ff[TMAG_W-1:0];
      rnd      = prod_ff + (PROD_W'(1) << FRAC_SH);
      off      = rnd[PROD_W-1 -: OFF_W];
      neg_axis = dc[MAG_W-1] ^ t_ff[T_W-1];
      cand     = {{4{s_ff[cmd.axis][COORD_W-1]}}, s_ff[cmd.axis]}
               + (neg_axis ? ((OFF_W+2)'(0) - {2'b00, off}) : {2'b00, off});
      if (!cand[OFF_W+1] && cand[OFF_W+1:COORD_W-1] != '0)
         axis_val = 32'h7FFF_FFFF;
      else if (cand[OFF_W+1] && cand[OFF_W+1:COORD_W-1] != '1)
         axis_val = 32'h8000_0000;
      else
         axis_val = cand[COORD_W-1:0];

      pair_val  = VAL_W'(dlen) + VAL_W'(ra_ff) + VAL_W'(rb_ff);
      need_val  = VAL_W'(dlen) + VAL_W'(rb_ff);
      out_free  = !rsp_valid_ff || !rsp_stall;
      take_axis = cmd.cand_sel && (radm_ff > rad_ff);
   end

   esc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_go),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (quo)
   );

   esc_dist u_dist (
      .clock (clock),
      .reset (reset),
      .start (cmd.dist_go),
      .pnt_a (pa_ff),
      .pnt_b (pb_ff),
      .done  (dist_done),
      .dlen  (dlen)
   );

   // child store
   always_ff @(posedge clock) begin
      if (cmd.load && count_ok && count_ff < CNT_W'(STORE_DEPTH)) begin
         mem_p[count_ff[ADDR_W-1:0]] <= pin;
         mem_r[count_ff[ADDR_W-1:0]] <= req_child_radius;
      end
      if (cmd.rd) begin
         rdp_ff <= mem_p[rd_addr];
         rdr_ff <= mem_r[rd_addr];
      end
   end

   // set accumulators and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            sum_ff       <= '0;
            count_ff     <= '0;
            ovf_ff       <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else begin
            if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
            if (cmd.load) begin
               if (count_ok) begin
                  for (int k = 0; k < 3; k++)
                     sum_ff[k] <= sum_ff[k] + {{(SUM_W-COORD_W){pin[k][COORD_W-1]}}, pin[k]};
                  count_ff <= count_ff + CNT_W'(1);
               end else begin
                  ovf_ff <= 1'b1;
               end
            end
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff      <= take_axis ? axis_ff : mean_ff;
         too_many_ff <= ovf_ff;
      end
      if (cmd.mean_save) mean_ff[cmd.axis] <= mean_val;
      if (cmd.axis_save) axis_ff[cmd.axis] <= axis_val;
      if (cmd.lat_a) begin
         pa_ff <= rdp_ff;
         ra_ff <= rdr_ff;
      end
      if (cmd.cand_a) pa_ff <= cmd.cand_sel ? axis_ff : mean_ff;
      if (cmd.lat_b) begin
         pb_ff <= rdp_ff;
         rb_ff <= rdr_ff;
      end
      if (cmd.pair_init) begin
         best_ff  <= '0;
         found_ff <= 1'b0;
      end
      if (cmd.pair_upd && pair_val > best_ff) begin
         best_ff  <= pair_val;
         found_ff <= 1'b1;
         s_ff     <= pa_ff;
         rs_ff    <= ra_ff;
         e_ff     <= pb_ff;
         re_ff    <= rb_ff;
         bestd_ff <= dlen;
      end
      if (cmd.t_calc) t_ff <= T_W'(bestd_ff) + T_W'(re_ff) - T_W'(rs_ff);
      if (cmd.mul) prod_ff <= PROD_W'(quo[Q_W-1:0]) * PROD_W'(t_mag);
      if (cmd.rad_init) rad_ff <= '0;
      if (cmd.rad_upd && need_val > rad_ff) rad_ff <= need_val;
      if (cmd.rad_keep) radm_ff <= rad_ff;
   end

   always_comb begin
      stat.div_done  = div_done;
      stat.dist_done = dist_done;
      stat.pair_ok   = count_ff < CNT_W'(STORE_DEPTH) && count_ff >= CNT_W'(2);
      stat.found     = found_ff;
      stat.d_zero    = bestd_ff == '0;
      stat.out_free  = out_free;
      stat.count     = count_ff;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_center_x = out_ff[0];
   assign rsp_center_y = out_ff[1];
   assign rsp_center_z = out_ff[2];
   assign rsp_too_many = too_many_ff;

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while still waiting");
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_COUNT))
      else $error("child count beyond limit");
   a_save_done: assert property (@(posedge clock) disable iff (reset)
      cmd.mean_save |-> div_done)
      else $error("quotient used before divider finished");
   a_upd_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.pair_upd || cmd.rad_upd) |-> dist_done)
      else $error("distance used before root finished");
endmodule
`default_nettype wire

### design/esc_ctrl.sv
// esc_ctrl: sequencer for loading, mean division, pair search, axis center and
// radius comparison; depends on esc_pkg
`default_nettype none
module esc_ctrl #(
   parameter int ADDR_W = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last_child,
   output logic                   req_stall,
   input  esc_pkg::esc_stat_type  stat,
   output esc_pkg::esc_cmd_type   cmd,
   output logic [ADDR_W-1:0]      rd_addr
);
   import esc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_MDIV, S_MWAIT, S_PINIT, S_PRDA, S_PRDB, S_PLATB, S_PDIST,
      S_PWAIT, S_PEND, S_ADIV, S_AWAIT, S_AMUL, S_ASAVE, S_RINIT, S_RRD,
      S_RLAT, S_RDIST, S_RWAIT, S_RKEEP, S_OUT
   } state_type;

   state_type         state_ff;
   logic [ADDR_W-1:0] i_ff, j_ff;
   logic [1:0]        k_ff;
   logic              sel_ff;
   logic              ax_ff;
   logic [ADDR_W-1:0] last;

   assign last = stat.count[ADDR_W-1:0] - ADDR_W'(1);

   always_comb begin
      cmd       = '0;
      cmd.axis  = k_ff;
      req_stall = state_ff != S_IDLE;
      rd_addr   = (state_ff == S_PRDB) ? j_ff : i_ff;
      case (state_ff)
         S_IDLE:  cmd.load = req_valid;
         S_MDIV:  cmd.div_go = 1'b1;
         S_MWAIT: cmd.mean_save = stat.div_done;
         S_PINIT: cmd.pair_init = 1'b1;
         S_PRDA:  cmd.rd = 1'b1;
         S_PRDB: begin
            cmd.rd    = 1'b1;
            cmd.lat_a = 1'b1;
         end
         S_PLATB: cmd.lat_b = 1'b1;
         S_PDIST: cmd.dist_go = 1'b1;
         S_PWAIT: cmd.pair_upd = stat.dist_done;
         S_PEND:  cmd.t_calc = stat.found && !stat.d_zero;
         S_ADIV: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = 1'b1;
         end
         S_AWAIT: cmd.div_sel = 1'b1;
         S_AMUL: begin
            cmd.div_sel = 1'b1;
            cmd.mul     = 1'b1;
         end
         S_ASAVE: cmd.axis_save = 1'b1;
         S_RINIT: cmd.rad_init = 1'b1;
         S_RRD: begin
            cmd.rd       = 1'b1;
            cmd.cand_a   = 1'b1;
            cmd.cand_sel = sel_ff;
         end
         S_RLAT:  cmd.lat_b = 1'b1;
         S_RDIST: cmd.dist_go = 1'b1;
         S_RWAIT: cmd.rad_upd = stat.dist_done;
         S_RKEEP: cmd.rad_keep = 1'b1;
         S_OUT: begin
            cmd.out_load = stat.out_free;
            cmd.cand_sel = ax_ff;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ax_ff    <= 1'b0;
         sel_ff   <= 1'b0;
         k_ff     <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_last_child) begin
                  k_ff     <= '0;
                  ax_ff    <= 1'b0;
                  state_ff <= S_MDIV;
               end
            end
            S_MDIV: state_ff <= S_MWAIT;
            S_MWAIT: begin
               if (stat.div_done) begin
                  if (k_ff == 2'd2) begin
                     state_ff <= stat.pair_ok ? S_PINIT : S_OUT;
                  end else begin
                     k_ff     <= k_ff + 2'd1;
                     state_ff <= S_MDIV;
                  end
               end
            end
            S_PINIT: begin
               i_ff     <= '0;
               j_ff     <= ADDR_W'(1);
               state_ff <= S_PRDA;
            end
            S_PRDA:  state_ff <= S_PRDB;
            S_PRDB:  state_ff <= S_PLATB;
            S_PLATB: state_ff <= S_PDIST;
            S_PDIST: state_ff <= S_PWAIT;
            S_PWAIT: begin
               if (stat.dist_done) begin
                  if (j_ff == last) begin
                     if (i_ff == last - ADDR_W'(1)) begin
                        state_ff <= S_PEND;
                     end else begin
                        i_ff     <= i_ff + ADDR_W'(1);
                        j_ff     <= i_ff + ADDR_W'(2);
                        state_ff <= S_PRDA;
                     end
                  end else begin
                     j_ff     <= j_ff + ADDR_W'(1);
                     state_ff <= S_PRDA;
                  end
               end
            end
            S_PEND: begin
               if (stat.found && !stat.d_zero) begin
                  ax_ff    <= 1'b1;
                  k_ff     <= '0;
                  state_ff <= S_ADIV;
               end else begin
                  state_ff <= S_OUT;
               end
            end
            S_ADIV: state_ff <= S_AWAIT;
            S_AWAIT: begin
               if (stat.div_done) state_ff <= S_AMUL;
            end
            S_AMUL: state_ff <= S_ASAVE;
            S_ASAVE: begin
               if (k_ff == 2'd2) begin
                  sel_ff   <= 1'b0;
                  state_ff <= S_RINIT;
               end else begin
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= S_ADIV;
               end
            end
            S_RINIT: begin
               i_ff     <= '0;
               state_ff <= S_RRD;
            end
            S_RRD:   state_ff <= S_RLAT;
            S_RLAT:  state_ff <= S_RDIST;
            S_RDIST: state_ff <= S_RWAIT;
            S_RWAIT: begin
               if (stat.dist_done) begin
                  if (i_ff == last) begin
                     state_ff <= sel_ff ? S_OUT : S_RKEEP;
                  end else begin
                     i_ff     <= i_ff + ADDR_W'(1);
                     state_ff <= S_RRD;
                  end
               end
            end
            S_RKEEP: begin
               sel_ff   <= 1'b1;
               state_ff <= S_RINIT;
            end
            S_OUT: begin
               if (stat.out_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

### tb/sv/enclosing_sphere_center_tb.sv
// enclosing_sphere_center_tb: self-checking bench, drives child spheres and checks
// each enclosing center against an in-bench fixed-point predictor
// depends on esc_pkg and enclosing_sphere_center
`timescale 1ns / 1ps

typedef struct {
   logic [esc_pkg::COORD_W-1:0] cx;
   logic [esc_pkg::COORD_W-1:0] cy;
   logic [esc_pkg::COORD_W-1:0] cz;
   logic                        too_many;
} center_type;

class center_scoreboard;
   localparam int STORE_N = 16;
   localparam int COUNT_MAX = 65535;

   longint         kept_x[STORE_N], kept_y[STORE_N], kept_z[STORE_N], kept_r[STORE_N];
   longint         acc_x, acc_y, acc_z;
   int unsigned    n_children;
   bit             dropped;
   center_type     centers_q[$];
   int unsigned    errors;

   function new();
      acc_x = 0; acc_y = 0; acc_z = 0;
      n_children = 0; dropped = 0; errors = 0;
   endfunction

   static function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   static function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // floor of the exact root of the squared distance, bit by bit
   static function longint unsigned span(longint ax, longint ay, longint az,
                                         longint bx, longint by, longint bz);
      logic [67:0] sq;
      logic [69:0] rem, trial;
      logic [69:0] root;
      sq = 68'(mag(ax - bx)) * 68'(mag(ax - bx)) + 68'(mag(ay - by)) * 68'(mag(ay - by))
         + 68'(mag(az - bz)) * 68'(mag(az - bz));
      rem = 0; root = 0;
      for (int i = 33; i >= 0; i--) begin
         rem = (rem << 2) | 70'(sq[2*i +: 2]);
         trial = (root << 2) | 70'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 70'd1;
         end else begin
            root = root << 1;
         end
      end
      return root[63:0];
   endfunction

   static function longint mean_of(longint s, int unsigned n);
      longint unsigned q;
      q = (2 * mag(s) + n) / (2 * longint'(n));
      return sat32(s < 0 ? -longint'(q) : longint'(q));
   endfunction

   static function longint axis_point(longint sc, longint ec, longint unsigned d, longint t);
      longint unsigned q, off;
      q = (mag(ec - sc) << 29) / d;
      off = (q * mag(t) + (64'd1 << 29)) >> 30;
      return sat32(((ec - sc < 0) != (t < 0)) ? sc - longint'(off) : sc + longint'(off));
   endfunction

   function longint unsigned need_radius(longint cx, longint cy, longint cz);
      longint unsigned best, need;
      best = 0;
      for (int i = 0; i < n_children && i < STORE_N; i++) begin
         need = span(cx, cy, cz, kept_x[i], kept_y[i], kept_z[i]) + kept_r[i];
         if (need > best) best = need;
      end
      return best;
   endfunction

   function void note_child(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [30:0] r, logic last);
      longint         cx, cy, cz, ax, ay, az, t;
      longint unsigned best, v, d;
      int             s, e;
      bit             found;
      center_type     c;
      if (n_children < COUNT_MAX) begin
         if (n_children < STORE_N) begin
            kept_x[n_children] = longint'($signed(x));
            kept_y[n_children] = longint'($signed(y));
            kept_z[n_children] = longint'($signed(z));
            kept_r[n_children] = longint'(r);
         end
         acc_x += longint'($signed(x));
         acc_y += longint'($signed(y));
         acc_z += longint'($signed(z));
         n_children++;
      end else begin
         dropped = 1;
      end
      if (!last) return;
      cx = mean_of(acc_x, n_children);
      cy = mean_of(acc_y, n_children);
      cz = mean_of(acc_z, n_children);
      // pair search only for at least two children and fewer than the store depth
      if (n_children < STORE_N && n_children >= 2) begin
         best = 0; s = 0; e = 0; found = 0;
         for (int i = 0; i < n_children; i++)
            for (int j = i + 1; j < n_children; j++) begin
               v = span(kept_x[i], kept_y[i], kept_z[i], kept_x[j], kept_y[j], kept_z[j])
                 + kept_r[i] + kept_r[j];
               if (v > best) begin
                  best = v; s = i; e = j; found = 1;
               end
            end
         if (found) begin
            d = span(kept_x[s], kept_y[s], kept_z[s], kept_x[e], kept_y[e], kept_z[e]);
            if (d != 0) begin
               t = longint'(d) + kept_r[e] - kept_r[s];
               ax = axis_point(kept_x[s], kept_x[e], d, t);
               ay = axis_point(kept_y[s], kept_y[e], d, t);
               az = axis_point(kept_z[s], kept_z[e], d, t);
               if (need_radius(cx, cy, cz) > need_radius(ax, ay, az)) begin
                  cx = ax; cy = ay; cz = az;
               end
            end
         end
      end
      c.cx = cx[31:0]; c.cy = cy[31:0]; c.cz = cz[31:0]; c.too_many = dropped;
      centers_q = {centers_q, c};
      acc_x = 0; acc_y = 0; acc_z = 0; n_children = 0; dropped = 0;
   endfunction

   task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task check_center(center_type got);
      center_type want;
      if (centers_q.size() == 0) begin
         report("unexpected center", got.cx, 32'd0);
         return;
      end
      want = centers_q.pop_front();
      if (got.cx !== want.cx) report("center_x", got.cx, want.cx);
      if (got.cy !== want.cy) report("center_y", got.cy, want.cy);
      if (got.cz !== want.cz) report("center_z", got.cz, want.cz);
      if (got.too_many !== want.too_many)
         report("too_many", 32'(got.too_many), 32'(want.too_many));
   endtask
endclass

module enclosing_sphere_center_tb;
   import esc_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [COORD_W-1:0] req_pos_x, req_pos_y, req_pos_z;
   logic [RAD_W-1:0]   req_child_radius;
   logic               req_last_child;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [COORD_W-1:0] rsp_center_x, rsp_center_y, rsp_center_z;
   logic               rsp_too_many;

   center_scoreboard sb = new();
   // quiet disables idling on both sides
   bit quiet;
   int unsigned sent;

   enclosing_sphere_center u_dut (.*);

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   // receiver stalls at random, never while quiet
   always @(negedge clock)
      rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 37);

   // both monitors sample at the rising edge, before the block's own updates land
   always @(posedge clock)
      if (!reset && req_valid && !req_stall)
         sb.note_child(req_pos_x, req_pos_y, req_pos_z, req_child_radius, req_last_child);

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_center('{rsp_center_x, rsp_center_y, rsp_center_z, rsp_too_many});

   // one child item; called at a falling edge and returns at one
   task send_child(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [30:0] r,
                   logic last);
      while (!quiet && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_pos_x        <= x;
      req_pos_y        <= y;
      req_pos_z        <= z;
      req_child_radius <= r;
      req_last_child   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   // random coordinate: full range or clustered around a base
   function automatic logic [31:0] rand_coord(bit wide, logic [31:0] base);
      if (wide) return $urandom;
      return base + 32'($signed($urandom_range(65536 * 64) - 65536 * 32));
   endfunction

   task random_set(int unsigned n);
      bit          wide;
      logic [31:0] bx, by, bz;
      logic [30:0] r;
      wide = ($urandom_range(3) == 0);
      bx = $urandom; by = $urandom; bz = $urandom;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: r = 31'($urandom);
            1: r = 0;
            default: r = 31'($urandom_range(65536 * 16));
         endcase
         send_child(rand_coord(wide, bx), rand_coord(wide, by), rand_coord(wide, bz), r,
                    i == n - 1);
      end
   endtask

   initial begin
      reset = 1'b1;
      quiet = 1'b0;
      sent = 0;
      req_valid = 1'b0;
      req_pos_x = '0; req_pos_y = '0; req_pos_z = '0;
      req_child_radius = '0;
      req_last_child = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single child at the extremes: the mean alone
      send_child(32'h7fffffff, 32'h80000000, 32'h0, 31'h7fffffff, 1);
      send_child(32'h80000000, 32'h7fffffff, 32'hffffffff, 31'h0, 1);
      // opposite corners, largest radii: the widest pair distance
      send_child(32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff, 0);
      send_child(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 1);
      // coincident pair centers with different radii
      send_child(32'h00010000, 32'h00020000, 32'h00030000, 31'h00050000, 0);
      send_child(32'h00010000, 32'h00020000, 32'h00030000, 31'h00010000, 1);
      // every pair sum zero
      send_child(32'h12345678, 32'h0, 32'hfedcba98, 31'h0, 0);
      send_child(32'h12345678, 32'h0, 32'hfedcba98, 31'h0, 1);
      // symmetric triple with equal radii: ties keep the mean
      send_child(32'hfffe0000, 32'h0, 32'h0, 31'h00010000, 0);
      send_child(32'h00020000, 32'h0, 32'h0, 31'h00010000, 0);
      send_child(32'h0, 32'h0, 32'h0, 31'h00010000, 1);
      // store just full, then one past it: mean only; then one short of full
      random_set(16);
      random_set(17);
      random_set(15);

      // random sets, mostly small so the pair search stays short
      while (sent < 1850) begin
         // one long run with no idling at all
         quiet = (sent > 700 && sent < 900);
         random_set($urandom_range(9) == 0 ? $urandom_range(7, 20) : $urandom_range(1, 6));
      end
      req_valid <= 1'b0;

      while (sb.centers_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0)
         $display("** enclosing_sphere_center: PASSED **");
      else
         $display("** enclosing_sphere_center: FAILED **");
      $finish;
   end

   initial begin
      #(12.0 * 8000000);
      $display("** enclosing_sphere_center: FAILED **");
      $finish;
   end
endmodule
